// ===== rtl/ltlt_pkg.sv =====
// ============================================================================
// ltlt_pkg
// Shared types and constants of the linked threshold LED timer.
// ============================================================================
package ltlt_pkg;

    // Defaults of the top-level parameters.
    localparam int CHANNELS_DEF     = 12;
    localparam int COUNTER_BITS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int CH_FIELD_W  = 4;
    localparam int VALUE_W     = 16;
    localparam int TIMER_W     = 15;
    localparam int LINK_W      = 48;
    localparam int LED_W       = 12;
    localparam int PORT_W      = 6;
    localparam int CFG_IDX_W   = 4;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // Decay used in delay mode when no decay is programmed.
    localparam logic [TIMER_W-1:0] FORCED_DECAY = 15'd1000;
    // Thresholds are stored as raw * 128.
    localparam int THRESH_SHIFT = 7;

    localparam logic [LINK_W-1:0] LINK_RESET = 48'hBA98_7654_3210;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ON = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK   = 4'd3;

    // Item kinds carried in tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_THRESH = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_DECAY,
        MODE_DECAY_MAX,
        MODE_DELAY
    } mode_t;

endpackage

// ===== rtl/linked_threshold_led_timer.sv =====
// ============================================================================
// linked_threshold_led_timer
// Per-channel threshold trigger with link groups and on-time shaping of the
// LED outputs; one result item per tick.
// ============================================================================
//
//  Channel   Dir  Bus               Content
//  s_*       in   tdata/tuser/tlast channel, value / operation / last_of_tick
//  m_*       out  tdata             led_on_mask, port_odd_mask, port_even_mask
//  cfg_*     in   we/index/data     decay, delay, max-on, link groups
//
//  One item is accepted per cycle. An item is registered in the input
//  stage, then updated against the channel state; a tick result reaches the
//  output register as its last item leaves the input stage.
//  The input stalls only while the output register holds an unaccepted
//  result and the staged item also ends a tick.
//  Reset sets all thresholds to disabled and every counter to zero.
//
module linked_threshold_led_timer #(
    parameter int CHANNELS     = ltlt_pkg::CHANNELS_DEF,
    parameter int COUNTER_BITS = ltlt_pkg::COUNTER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel [3:0], value [19:4], zero [23:20]
    input  logic [ltlt_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation [0]
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // led_on_mask [11:0], port_odd_mask [17:12], port_even_mask [23:18]
    output logic [ltlt_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration.
    input  logic                                cfg_we,
    input  logic [ltlt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ltlt_pkg::LINK_W-1:0]         cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CB   = COUNTER_BITS;
    localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [ltlt_pkg::CH_FIELD_W:0] CH_LIMIT = (ltlt_pkg::CH_FIELD_W+1)'(CHANNELS);

    typedef logic signed [CB-1:0] cnt_t;
    typedef logic signed [ltlt_pkg::VALUE_W-1:0] val_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [ltlt_pkg::TIMER_W-1:0] decay_reg, delay_reg, max_on_reg;
    logic [ltlt_pkg::TIMER_W-1:0] decay_next, delay_next, max_on_next;
    logic [ltlt_pkg::LINK_W-1:0]  link_reg, link_next;
    logic                         reload;

    always_comb
    begin
        decay_next  = decay_reg;
        delay_next  = delay_reg;
        max_on_next = max_on_reg;
        link_next   = link_reg;
        reload      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                ltlt_pkg::REG_DECAY:
                begin
                    decay_next = cfg_data[ltlt_pkg::TIMER_W-1:0];
                    reload     = 1'b1;
                end
                ltlt_pkg::REG_DELAY:
                begin
                    delay_next = cfg_data[ltlt_pkg::TIMER_W-1:0];
                    reload     = 1'b1;
                end
                ltlt_pkg::REG_MAX_ON:
                begin
                    max_on_next = cfg_data[ltlt_pkg::TIMER_W-1:0];
                    reload      = 1'b1;
                end
                ltlt_pkg::REG_LINK:
                begin
                    link_next = cfg_data;
                end
                default:
                begin
                    reload = 1'b0;
                end
            endcase
        end
    end

    function automatic cnt_t load_cnt(input logic [ltlt_pkg::TIMER_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > 32'(CNT_MAX))
            return CNT_MAX;
        return CB'(v);
    endfunction

    // Saturating decrement: stays at -1.
    function automatic cnt_t dec_cnt(input cnt_t x);
        if (x[CB-1])
            return '1;
        return x - cnt_t'(1);
    endfunction

    function automatic logic is_pos(input cnt_t x);
        return !x[CB-1] && (x != '0);
    endfunction

    // Effective timing for the datapath and for a reload.
    logic [ltlt_pkg::TIMER_W-1:0] eff_decay, eff_max;
    logic [ltlt_pkg::TIMER_W-1:0] new_decay, new_max;
    ltlt_pkg::mode_t              mode;

    always_comb
    begin
        eff_decay = decay_reg;
        eff_max   = max_on_reg;
        if (delay_reg != '0)
        begin
            eff_max = '0;
            if (decay_reg == '0)
                eff_decay = ltlt_pkg::FORCED_DECAY;
        end
        new_decay = decay_next;
        new_max   = max_on_next;
        if (delay_next != '0)
        begin
            new_max = '0;
            if (decay_next == '0)
                new_decay = ltlt_pkg::FORCED_DECAY;
        end
        if (delay_reg != '0)
            mode = ltlt_pkg::MODE_DELAY;
        else if (eff_max != '0)
            mode = ltlt_pkg::MODE_DECAY_MAX;
        else if (eff_decay != '0)
            mode = ltlt_pkg::MODE_DECAY;
        else
            mode = ltlt_pkg::MODE_PLAIN;
    end

    // ------------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------------
    logic                                st_valid_reg;
    logic                                st_op_reg;
    logic [ltlt_pkg::CH_FIELD_W-1:0]     st_ch_reg;
    val_t                                st_value_reg;
    logic                                st_last_reg;
    logic                                st_emit;
    logic                                advance;
    logic                                out_valid_reg;
    logic [ltlt_pkg::M_TDATA_W-1:0]      out_data_reg;

    assign st_emit  = (st_op_reg == ltlt_pkg::OP_SAMPLE) && st_last_reg;
    assign advance  = st_valid_reg && (!st_emit || !out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            st_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            st_op_reg    <= s_tuser;
            st_ch_reg    <= s_tdata[ltlt_pkg::CH_FIELD_W-1:0];
            st_value_reg <= s_tdata[ltlt_pkg::CH_FIELD_W +: ltlt_pkg::VALUE_W];
            st_last_reg  <= s_tlast;
        end
    end

    // ------------------------------------------------------------------------
    // Channel state and update
    // ------------------------------------------------------------------------
    val_t                  thresh_reg [CHANNELS];
    cnt_t                  decay_cnt_reg [CHANNELS];
    cnt_t                  delay_cnt_reg [CHANNELS];
    cnt_t                  max_cnt_reg [CHANNELS];
    logic [CHANNELS-1:0]   pending_reg;

    logic                  ch_ok;
    logic [CH_W-1:0]       ch_idx;
    val_t                  th;
    cnt_t                  dc, dl, mx, dc_n, dl_n, mx_n;
    logic                  over, lit;
    logic [63:0]           link_wide;
    logic [3:0]            grp_sel;
    logic [CHANNELS-1:0]   grp_mask, hit_mask, pending_next;
    val_t                  th_new;

    assign ch_ok     = {1'b0, st_ch_reg} < CH_LIMIT;
    assign ch_idx    = st_ch_reg[CH_W-1:0];
    assign link_wide = 64'(link_reg);
    assign grp_sel   = link_wide[4*st_ch_reg +: 4];

    always_comb
    begin
        for (int j = 0; j < CHANNELS; j++)
            grp_mask[j] = (link_wide[4*j +: 4] == grp_sel);
    end

    // Scaled threshold with saturation; -1 and 0 keep their meaning.
    always_comb
    begin
        if (st_value_reg == '1)
            th_new = '1;
        else if (st_value_reg > val_t'(255))
            th_new = val_t'(16'sh7FFF);
        else if (st_value_reg < val_t'(-256))
            th_new = val_t'(16'sh8000);
        else
            th_new = {st_value_reg[ltlt_pkg::VALUE_W-ltlt_pkg::THRESH_SHIFT-1:0],
                      {ltlt_pkg::THRESH_SHIFT{1'b0}}};
    end

    always_comb
    begin
        th   = ch_ok ? thresh_reg[ch_idx] : '1;
        dc   = ch_ok ? decay_cnt_reg[ch_idx] : '0;
        dl   = ch_ok ? delay_cnt_reg[ch_idx] : '0;
        mx   = ch_ok ? max_cnt_reg[ch_idx] : '0;
        dc_n = dc;
        dl_n = dl;
        mx_n = mx;
        lit  = 1'b0;
        over = st_value_reg > th;
        if (st_op_reg == ltlt_pkg::OP_SAMPLE && ch_ok && th != '1)
        begin
            if (th == '0)
            begin
                lit = 1'b1;
            end
            else
            begin
                case (mode)
                    ltlt_pkg::MODE_PLAIN:
                    begin
                        lit = over;
                    end
                    ltlt_pkg::MODE_DECAY:
                    begin
                        if (over)
                        begin
                            lit  = 1'b1;
                            dc_n = load_cnt(eff_decay);
                        end
                        else if (is_pos(dc))
                        begin
                            dc_n = dc - cnt_t'(1);
                            lit  = 1'b1;
                        end
                    end
                    ltlt_pkg::MODE_DECAY_MAX:
                    begin
                        // The max-on count limits every lit tick.
                        if (over)
                        begin
                            if (eff_decay != '0)
                                dc_n = load_cnt(eff_decay);
                            mx_n = dec_cnt(mx);
                            lit  = is_pos(mx);
                        end
                        else if (eff_decay != '0)
                        begin
                            dc_n = dec_cnt(dc);
                            if (is_pos(dc))
                            begin
                                mx_n = dec_cnt(mx);
                                lit  = is_pos(mx);
                            end
                            else
                            begin
                                mx_n = load_cnt(eff_max);
                            end
                        end
                        else
                        begin
                            mx_n = load_cnt(eff_max);
                        end
                    end
                    default:
                    begin
                        // Delay mode: light once the delay has run out.
                        if (over)
                        begin
                            dl_n = load_cnt(delay_reg);
                            dc_n = load_cnt(eff_decay);
                        end
                        else
                        begin
                            dl_n = dec_cnt(dl);
                            if (is_pos(dl))
                            begin
                                dc_n = load_cnt(eff_decay);
                            end
                            else
                            begin
                                dc_n = dec_cnt(dc);
                                if (!dc[CB-1])
                                    lit = 1'b1;
                                else
                                    mx_n = load_cnt(eff_max);
                            end
                        end
                    end
                endcase
            end
        end
        hit_mask     = lit ? grp_mask : '0;
        pending_next = pending_reg | hit_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= '0;
            delay_reg   <= '0;
            max_on_reg  <= '0;
            link_reg    <= ltlt_pkg::LINK_RESET;
            pending_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                thresh_reg[i]    <= '1;
                decay_cnt_reg[i] <= '0;
                delay_cnt_reg[i] <= '0;
                max_cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            decay_reg  <= decay_next;
            delay_reg  <= delay_next;
            max_on_reg <= max_on_next;
            link_reg   <= link_next;
            if (advance && st_op_reg == ltlt_pkg::OP_THRESH && ch_ok)
                thresh_reg[ch_idx] <= th_new;
            // A timing write reloads all counters and wins over an update.
            if (reload)
            begin
                pending_reg <= '0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    decay_cnt_reg[i] <= '0;
                    delay_cnt_reg[i] <= load_cnt(delay_next);
                    max_cnt_reg[i]   <= load_cnt(new_max);
                end
            end
            else if (advance && st_op_reg == ltlt_pkg::OP_SAMPLE)
            begin
                if (ch_ok)
                begin
                    decay_cnt_reg[ch_idx] <= dc_n;
                    delay_cnt_reg[ch_idx] <= dl_n;
                    max_cnt_reg[ch_idx]   <= mx_n;
                end
                pending_reg <= st_last_reg ? '0 : pending_next;
            end
        end
    end

    // Delay mode always brings a nonzero decay time with it.
    logic reload_decay_zero;
    assign reload_decay_zero = (new_decay == '0);

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    logic [15:0]               mask_wide;
    logic [ltlt_pkg::PORT_W-1:0] port_odd, port_even;

    always_comb
    begin
        mask_wide = 16'(pending_next);
        for (int k = 0; k < ltlt_pkg::PORT_W; k++)
        begin
            port_odd[k]  = mask_wide[2*k];
            port_even[k] = mask_wide[2*k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && st_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && st_emit)
            out_data_reg <= {port_even, port_odd, mask_wide[ltlt_pkg::LED_W-1:0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (st_valid_reg && st_emit && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_reload_clears: assert property (@(posedge clk) disable iff (!rst_n)
        reload |=> (pending_reg == '0))
        else $error("pending mask not cleared by a timing write");

    a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st_emit) |=> m_tvalid)
        else $error("tick result not presented");

    a_forced_decay: assert property (@(posedge clk) disable iff (!rst_n)
        (reload && delay_next != '0) |-> !reload_decay_zero)
        else $error("delay mode without a decay time");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench of linked_threshold_led_timer
// Drives per-channel sample and threshold items through the input stream,
// steps a behavioral copy of the channel counters and link groups for every
// accepted item, and compares each tick result with the predicted LED masks.
// The run walks the plain, decay, decay with max-on and delay modes under
// several link groupings, with random idling on both streams.
// ============================================================================
module tb;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int NUM_CH          = ltlt_pkg::CHANNELS_DEF;
    localparam int NUM_PHASES      = 12;
    localparam int TICKS_PER_PHASE = 13;
    localparam int HOLD_AFTER      = 20;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int END_CYCLES      = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PAD_W           = ltlt_pkg::S_TDATA_W - ltlt_pkg::VALUE_W
                                     - ltlt_pkg::CH_FIELD_W;

    typedef struct packed {
        logic                op;
        logic [3:0]          ch;
        logic signed [15:0]  val;
        logic                last;
    } led_item_t;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [ltlt_pkg::PORT_W-1:0] even;
        logic [ltlt_pkg::PORT_W-1:0] odd;
        logic [ltlt_pkg::LED_W-1:0]  mask;
    } led_frame_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ltlt_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ltlt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            cfg_we = 1'b0;
    logic [ltlt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ltlt_pkg::LINK_W-1:0]     cfg_data = '0;

    // Predicted channel state.
    int                           thr_tab[NUM_CH];
    int                           decay_cnt[NUM_CH];
    int                           delay_cnt[NUM_CH];
    int                           max_on_cnt[NUM_CH];
    logic [ltlt_pkg::LED_W-1:0]   lit_pending;
    logic [ltlt_pkg::TIMER_W-1:0] decay_reg;
    logic [ltlt_pkg::TIMER_W-1:0] delay_reg;
    logic [ltlt_pkg::TIMER_W-1:0] max_on_reg;
    logic [ltlt_pkg::LINK_W-1:0]  link_reg;
    int                           eff_decay;
    int                           eff_delay;
    int                           eff_max;
    ltlt_pkg::mode_t              led_mode;

    led_item_t  pending_items[$];
    led_frame_t expected_frames[$];
    led_item_t  tx_item;
    led_frame_t rx_frame;
    led_frame_t want_frame;
    int         tx_gap = 0;
    int         rx_stall = 0;
    int         items_queued = 0;
    int         items_sent = 0;
    int         frames_seen = 0;
    int         errors = 0;
    int         quiet_cycles = 0;
    bit         no_idle = 1'b0;

    // Stimulus-side view of the thresholds and of channel activity.
    logic [15:0] gen_raw[NUM_CH];
    bit          gen_active[NUM_CH];

    int ph_decay[NUM_PHASES] = '{0, 3, 2, 0, 0, 2, 5, 32767, 0, 1, 32767, 4};
    int ph_delay[NUM_PHASES] = '{0, 0, 0, 0, 2, 3, 1, 0, 32767, 2, 32767, 0};
    int ph_max[NUM_PHASES]   = '{0, 0, 4, 3, 5, 0, 0, 32767, 0, 0, 32767, 1};

    linked_threshold_led_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic int scaled_thr(logic [15:0] raw);
        int t;
        if ($signed(raw) == -1)
            return -1;
        t = int'($signed(raw)) * (1 << ltlt_pkg::THRESH_SHIFT);
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t;
    endfunction

    function automatic int count_down(int x);
        return (x > -1) ? x - 1 : -1;
    endfunction

    // All loaded values fit in 15 bits, so a load never needs to saturate.
    function automatic void reload_timers();
        eff_delay = int'(delay_reg);
        eff_decay = int'(decay_reg);
        eff_max   = int'(max_on_reg);
        if (eff_delay > 0)
        begin
            eff_max = 0;
            if (eff_decay == 0)
                eff_decay = int'(ltlt_pkg::FORCED_DECAY);
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            decay_cnt[c]  = 0;
            delay_cnt[c]  = eff_delay;
            max_on_cnt[c] = eff_max;
        end
        lit_pending = '0;
        if (eff_delay == 0 && eff_max == 0 && eff_decay == 0)
            led_mode = ltlt_pkg::MODE_PLAIN;
        else if (eff_delay == 0 && eff_max == 0)
            led_mode = ltlt_pkg::MODE_DECAY;
        else if (eff_delay == 0)
            led_mode = ltlt_pkg::MODE_DECAY_MAX;
        else
            led_mode = ltlt_pkg::MODE_DELAY;
    endfunction

    function automatic void reset_model();
        decay_reg  = '0;
        delay_reg  = '0;
        max_on_reg = '0;
        link_reg   = ltlt_pkg::LINK_RESET;
        for (int c = 0; c < NUM_CH; c++)
            thr_tab[c] = -1;
        reload_timers();
    endfunction

    function automatic void apply_cfg(logic [ltlt_pkg::CFG_IDX_W-1:0] idx,
                                      logic [ltlt_pkg::LINK_W-1:0] data);
        case (idx)
            ltlt_pkg::REG_DECAY:
            begin
                decay_reg = data[ltlt_pkg::TIMER_W-1:0];
                reload_timers();
            end
            ltlt_pkg::REG_DELAY:
            begin
                delay_reg = data[ltlt_pkg::TIMER_W-1:0];
                reload_timers();
            end
            ltlt_pkg::REG_MAX_ON:
            begin
                max_on_reg = data[ltlt_pkg::TIMER_W-1:0];
                reload_timers();
            end
            ltlt_pkg::REG_LINK:
                link_reg = data;
            default:
                ;
        endcase
    endfunction

    function automatic void light_group(int c);
        logic [3:0] g;
        g = link_reg[4*c +: 4];
        for (int j = 0; j < NUM_CH; j++)
            if (link_reg[4*j +: 4] == g)
                lit_pending[j] = 1'b1;
    endfunction

    function automatic void light_limited(int c);
        int old;
        if (eff_max > 0)
        begin
            old = max_on_cnt[c];
            max_on_cnt[c] = count_down(old);
            if (old > 0)
                light_group(c);
        end
        else
        begin
            light_group(c);
        end
    endfunction

    function automatic void update_channel(int c, int s);
        int th;
        int old;
        bit over;
        th = thr_tab[c];
        if (th == -1)
            return;
        if (th == 0)
        begin
            light_group(c);
            return;
        end
        over = s > th;
        case (led_mode)
            ltlt_pkg::MODE_PLAIN:
            begin
                if (over)
                    light_group(c);
            end
            ltlt_pkg::MODE_DECAY:
            begin
                if (over)
                begin
                    light_group(c);
                    decay_cnt[c] = eff_decay;
                end
                else if (eff_decay > 0 && decay_cnt[c] > 0)
                begin
                    decay_cnt[c]--;
                    light_group(c);
                end
            end
            ltlt_pkg::MODE_DECAY_MAX:
            begin
                if (over)
                begin
                    if (eff_decay > 0)
                        decay_cnt[c] = eff_decay;
                    light_limited(c);
                end
                else if (eff_decay > 0)
                begin
                    old = decay_cnt[c];
                    decay_cnt[c] = count_down(old);
                    if (old > 0)
                        light_limited(c);
                    else
                        max_on_cnt[c] = eff_max;
                end
                else
                begin
                    max_on_cnt[c] = eff_max;
                end
            end
            default:
            begin
                // Delay mode: activity restarts both counters, the LED lights
                // only once the delay has run out and while decay lasts.
                if (over)
                begin
                    delay_cnt[c] = eff_delay;
                    decay_cnt[c] = eff_decay;
                end
                else
                begin
                    old = delay_cnt[c];
                    delay_cnt[c] = count_down(old);
                    if (old > 0)
                    begin
                        decay_cnt[c] = eff_decay;
                    end
                    else
                    begin
                        old = decay_cnt[c];
                        decay_cnt[c] = count_down(old);
                        if (old >= 0)
                            light_group(c);
                        else
                            max_on_cnt[c] = eff_max;
                    end
                end
            end
        endcase
    endfunction

    function automatic void take_item(led_item_t it);
        led_frame_t f;
        if (it.op == ltlt_pkg::OP_THRESH)
        begin
            if (it.ch < NUM_CH)
                thr_tab[it.ch] = scaled_thr(it.val);
            return;
        end
        if (it.ch < NUM_CH)
            update_channel(int'(it.ch), int'($signed(it.val)));
        if (!it.last)
            return;
        f.mask = lit_pending;
        for (int k = 0; k < ltlt_pkg::PORT_W; k++)
        begin
            f.odd[k]  = lit_pending[2*k];
            f.even[k] = lit_pending[2*k+1];
        end
        expected_frames.push_back(f);
        lit_pending = '0;
    endfunction

    function automatic void queue_item(logic op, logic [3:0] ch, logic [15:0] val, logic last);
        led_item_t it;
        it.op   = op;
        it.ch   = ch;
        it.val  = val;
        it.last = last;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void queue_noise();
        logic        op;
        logic [3:0]  ch;
        logic [15:0] val;
        op  = 1'($urandom_range(0, 1));
        ch  = 4'($urandom_range(0, 15));
        val = 16'($urandom_range(0, 65535));
        if (op == ltlt_pkg::OP_THRESH && ch < NUM_CH)
            gen_raw[ch] = val;
        queue_item(op, ch, val, 1'($urandom_range(0, 1)));
    endfunction

    function automatic void queue_thresholds();
        int r;
        logic [15:0] raw;
        for (int c = 0; c < NUM_CH; c++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                raw = 16'hFFFF;
            else if (r < 20)
                raw = 16'h0000;
            else if (r < 85)
                raw = 16'($urandom_range(1, 255));
            else
                raw = 16'($urandom_range(0, 65535));
            gen_raw[c] = raw;
            queue_item(ltlt_pkg::OP_THRESH, 4'(c), raw, 1'($urandom_range(0, 1)));
        end
    endfunction

    // One tick of samples, channels in order; now and then a channel is
    // left out or a stray item is slipped in.
    function automatic void queue_tick();
        bit send[NUM_CH];
        int last_ch;
        int t;
        int v;
        last_ch = -1;
        for (int c = 0; c < NUM_CH; c++)
        begin
            send[c] = ($urandom_range(0, 19) != 0);
            if (send[c])
                last_ch = c;
        end
        if (last_ch < 0)
        begin
            send[NUM_CH-1] = 1'b1;
            last_ch = NUM_CH - 1;
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            if ($urandom_range(0, 24) == 0)
                queue_noise();
            if (send[c])
            begin
                if ($urandom_range(0, 3) == 0)
                    gen_active[c] = !gen_active[c];
                t = scaled_thr(gen_raw[c]);
                if ($urandom_range(0, 9) == 0)
                    v = int'($urandom_range(0, 65535)) - 32768;
                else if (gen_active[c])
                    v = t + $urandom_range(1, 200);
                else
                    v = t - $urandom_range(0, 200);
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                queue_item(ltlt_pkg::OP_SAMPLE, 4'(c), 16'(v), c == last_ch);
            end
        end
    endfunction

    task automatic write_reg(logic [ltlt_pkg::CFG_IDX_W-1:0] idx,
                             logic [ltlt_pkg::LINK_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_cfg(idx, data);
        cfg_we    <= 1'b0;
    endtask

    // Timer registers get random junk above bit 14 to check the masking.
    function automatic logic [ltlt_pkg::LINK_W-1:0] timer_word(int ticks);
        logic [ltlt_pkg::LINK_W-1:0] w;
        w = ltlt_pkg::LINK_W'({$urandom, $urandom});
        w[ltlt_pkg::TIMER_W-1:0] = ltlt_pkg::TIMER_W'(ticks);
        return w;
    endfunction

    task automatic wait_idle();
        while (items_sent != items_queued || expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timers(int ph);
        if ($urandom_range(0, 1))
        begin
            write_reg(ltlt_pkg::REG_DECAY, timer_word(ph_decay[ph]));
            write_reg(ltlt_pkg::REG_DELAY, timer_word(ph_delay[ph]));
            write_reg(ltlt_pkg::REG_MAX_ON, timer_word(ph_max[ph]));
        end
        else
        begin
            write_reg(ltlt_pkg::REG_MAX_ON, timer_word(ph_max[ph]));
            write_reg(ltlt_pkg::REG_DELAY, timer_word(ph_delay[ph]));
            write_reg(ltlt_pkg::REG_DECAY, timer_word(ph_decay[ph]));
        end
    endtask

    // Input driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                take_item(tx_item);
                items_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    tx_item = pending_items.pop_front();
                    s_tdata  <= {{PAD_W{1'b0}}, tx_item.val, tx_item.ch};
                    s_tuser  <= tx_item.op;
                    s_tlast  <= tx_item.last;
                    s_tvalid <= 1'b1;
                    tx_gap = no_idle ? 0 : idle_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                rx_frame = m_tdata;
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, got %h", $time, m_tdata);
                end
                else
                begin
                    want_frame = expected_frames.pop_front();
                    if (rx_frame.mask !== want_frame.mask)
                    begin
                        errors++;
                        $display("%0t: led_on_mask expected %h got %h",
                                 $time, want_frame.mask, rx_frame.mask);
                    end
                    if (rx_frame.odd !== want_frame.odd)
                    begin
                        errors++;
                        $display("%0t: port_odd_mask expected %h got %h",
                                 $time, want_frame.odd, rx_frame.odd);
                    end
                    if (rx_frame.even !== want_frame.even)
                    begin
                        errors++;
                        $display("%0t: port_even_mask expected %h got %h",
                                 $time, want_frame.even, rx_frame.even);
                    end
                end
                frames_seen++;
                // One long hold-off so the input side backs up.
                if (frames_seen == HOLD_AFTER)
                    rx_stall = HOLD_CYCLES;
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = no_idle ? 0 : idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ltlt_pkg::LINK_W-1:0] grp;
        reset_model();
        for (int c = 0; c < NUM_CH; c++)
        begin
            gen_raw[c] = 16'hFFFF;
            gen_active[c] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Threshold encodings: always on, disabled with a stray last flag,
        // smallest and largest raw values, saturation both ways, and a write
        // to a channel that does not exist.
        queue_item(ltlt_pkg::OP_THRESH, 4'd0, 16'sd0, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd1, -16'sd1, 1'b1);
        queue_item(ltlt_pkg::OP_THRESH, 4'd2, 16'sd1, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd3, 16'sd255, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd4, 16'sd32767, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd5, -16'sd32768, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd6, -16'sd2, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd13, 16'sd5, 1'b0);
        queue_item(ltlt_pkg::OP_THRESH, 4'd7, 16'sd300, 1'b0);
        // Samples at the value extremes and right at the thresholds.
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd0, -16'sd32768, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd1, 16'sd32767, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd2, 16'sd129, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd3, 16'sd32640, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd4, 16'sd32767, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd5, -16'sd32767, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd6, -16'sd256, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd7, 16'sd0, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd14, 16'sd123, 1'b0);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd11, 16'sd5, 1'b0);
        // A tick closed by a sample for a nonexistent channel.
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd15, -16'sd1, 1'b1);
        // Ticks with most channels missing.
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd2, 16'sd128, 1'b1);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd5, -16'sd32768, 1'b1);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd12, 16'sd1000, 1'b1);
        queue_item(ltlt_pkg::OP_SAMPLE, 4'd0, 16'sd7, 1'b1);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            no_idle = (ph % 3 == 1);
            case (ph % 4)
                0:
                    grp = ltlt_pkg::LINK_RESET;
                1:
                    grp = '0;
                2:
                begin
                    grp = '0;
                    for (int c = 0; c < NUM_CH; c++)
                        grp[4*c +: 4] = 4'($urandom_range(0, 3));
                end
                default:
                    grp = ltlt_pkg::LINK_W'({$urandom, $urandom});
            endcase
            if (ph == NUM_PHASES - 1)
                grp = '1;
            // An index past the last register must be ignored.
            write_reg(ltlt_pkg::CFG_IDX_W'($urandom_range(ltlt_pkg::REG_LINK + 1, 15)),
                      ltlt_pkg::LINK_W'({$urandom, $urandom}));
            if ($urandom_range(0, 1))
            begin
                write_reg(ltlt_pkg::REG_LINK, grp);
                write_timers(ph);
            end
            else
            begin
                write_timers(ph);
                write_reg(ltlt_pkg::REG_LINK, grp);
            end
            queue_thresholds();
            for (int k = 0; k < TICKS_PER_PHASE; k++)
                queue_tick();
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== linked_threshold_led_timer.f =====
rtl/ltlt_pkg.sv
rtl/linked_threshold_led_timer.sv
tb/tb.sv
